[rtl/core/clipped_rectangle_fill_top_macros.svh]
// Assertion macros for the clipped rectangle fill block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CLIPPED_RECTANGLE_FILL_TOP_MACROS_SVH
`define CLIPPED_RECTANGLE_FILL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRF_ASSERT_SAME(label, ante, cons, msg)
`define CRF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/crf_pkg.sv]
`default_nettype none

package crf_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;
    localparam int unsigned DEF_COLOR_BITS = 4;

    localparam int unsigned CMD_W       = 2;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned COLOR_W     = 4;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned SIZE_W      = 7;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam int unsigned IN_TDATA_W  = 4 * COORD_W + COLOR_W + 2 * POS_W;
    localparam int unsigned OUT_PAD_W   = 3;
    localparam int unsigned OUT_TDATA_W = 1 + COLOR_W + OUT_PAD_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_CANVAS_WIDTH  = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_CANVAS_HEIGHT = 7'd64;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND    = 4'd0;

    typedef enum logic [2:0] {
        ST_START,
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_PAINT,
        ST_READ,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic init_load;
        logic decode;
        logic step;
        logic rd_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic is_read;
        logic is_empty;
        logic last_pixel;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/crf_ram.sv]
`default_nettype none

module crf_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/crf_ctrl.sv]
`default_nettype none

module crf_ctrl
    import crf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       ctl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_START:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (stat.last_pixel)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.reject || stat.is_empty)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.is_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_PAINT;
                end
            end
            ST_PAINT:
            begin
                if (stat.last_pixel)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_START:
            begin
                ctl.init_load = 1'b1;
            end
            ST_SWEEP, ST_PAINT:
            begin
                ctl.step = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                ctl.capture = s_tvalid;
            end
            ST_DECODE:
            begin
                ctl.decode = 1'b1;
            end
            ST_READ:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_DONE:
            begin
                ctl.out_load = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/crf_datapath.sv]
`default_nettype none

module crf_datapath
    import crf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned COLOR_BITS = DEF_COLOR_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [CMD_W-1:0]       s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire dp_cmd_t                ctl,
    output dp_stat_t                    stat
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned SW    = COORD_W + 2;

    // Configuration registers.
    logic [SIZE_W-1:0]  cw_reg;
    logic [SIZE_W-1:0]  ch_reg;
    logic [COLOR_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= RST_CANVAS_WIDTH;
            ch_reg <= RST_CANVAS_HEIGHT;
            bg_reg <= RST_BACKGROUND;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                REG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                REG_BACKGROUND:    bg_reg <= cfg_data[COLOR_W-1:0];
                default:           ;
            endcase
        end
    end

    logic [WW-1:0] act_w;
    logic [HW-1:0] act_h;

    always_comb
    begin
        if (cw_reg == '0)
        begin
            act_w = WW'(1);
        end
        else if (32'(cw_reg) > MAX_WIDTH)
        begin
            act_w = WW'(MAX_WIDTH);
        end
        else
        begin
            act_w = WW'(cw_reg);
        end
        if (ch_reg == '0)
        begin
            act_h = HW'(1);
        end
        else if (32'(ch_reg) > MAX_HEIGHT)
        begin
            act_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            act_h = HW'(ch_reg);
        end
    end

    // Captured command.
    logic [CMD_W-1:0]   cap_cmd_reg;
    logic [COORD_W-1:0] cap_left_reg;
    logic [COORD_W-1:0] cap_top_reg;
    logic [COORD_W-1:0] cap_right_reg;
    logic [COORD_W-1:0] cap_bottom_reg;
    logic [COLOR_W-1:0] cap_color_reg;
    logic [POS_W-1:0]   cap_col_reg;
    logic [POS_W-1:0]   cap_row_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cap_cmd_reg    <= s_tuser;
            cap_left_reg   <= s_tdata[15:0];
            cap_top_reg    <= s_tdata[31:16];
            cap_right_reg  <= s_tdata[47:32];
            cap_bottom_reg <= s_tdata[63:48];
            cap_color_reg  <= s_tdata[67:64];
            cap_col_reg    <= s_tdata[73:68];
            cap_row_reg    <= s_tdata[79:74];
        end
    end

    logic signed [SW-1:0] left_s;
    logic signed [SW-1:0] top_s;
    logic signed [SW-1:0] right_s;
    logic signed [SW-1:0] bottom_s;
    logic signed [SW-1:0] w_s;
    logic signed [SW-1:0] h_s;
    logic                 fill_off;
    logic                 read_off;
    logic                 reject;
    logic [WW-1:0]        w_m1;
    logic [HW-1:0]        h_m1;

    assign left_s   = {{2{cap_left_reg[COORD_W-1]}}, cap_left_reg};
    assign top_s    = {{2{cap_top_reg[COORD_W-1]}}, cap_top_reg};
    assign right_s  = {{2{cap_right_reg[COORD_W-1]}}, cap_right_reg};
    assign bottom_s = {{2{cap_bottom_reg[COORD_W-1]}}, cap_bottom_reg};
    assign w_s      = signed'(SW'(act_w));
    assign h_s      = signed'(SW'(act_h));
    assign w_m1     = act_w - WW'(1);
    assign h_m1     = act_h - HW'(1);

    assign fill_off = (left_s >= w_s) || (top_s >= h_s) ||
                      (right_s < 0) || (bottom_s < 0);
    assign read_off = (32'(cap_col_reg) >= 32'(act_w)) ||
                      (32'(cap_row_reg) >= 32'(act_h));

    always_comb
    begin
        case (cap_cmd_reg)
            CMD_CLEAR: reject = 1'b0;
            CMD_FILL:  reject = fill_off;
            CMD_READ:  reject = read_off;
            default:   reject = 1'b1;
        endcase
    end

    assign stat.reject   = reject;
    assign stat.is_read  = (cap_cmd_reg == CMD_READ);
    assign stat.is_empty = (cap_cmd_reg == CMD_FILL) &&
                           ((left_s > right_s) || (top_s > bottom_s));

    // Bounds of the area to paint.
    logic [XW-1:0]         ld_left;
    logic [XW-1:0]         ld_right;
    logic [YW-1:0]         ld_top;
    logic [YW-1:0]         ld_bottom;
    logic [COLOR_BITS-1:0] ld_color;
    logic [COLOR_BITS+COLOR_W-1:0] fill_ext;
    logic [COLOR_BITS+COLOR_W-1:0] bg_ext;
    logic [31:0]           ld_base;

    assign fill_ext = {{COLOR_BITS{1'b0}}, cap_color_reg};
    assign bg_ext   = {{COLOR_BITS{1'b0}}, bg_reg};

    always_comb
    begin
        if (ctl.init_load)
        begin
            ld_left   = '0;
            ld_right  = XW'(MAX_WIDTH - 1);
            ld_top    = '0;
            ld_bottom = YW'(MAX_HEIGHT - 1);
            ld_color  = '0;
        end
        else if (cap_cmd_reg == CMD_CLEAR)
        begin
            ld_left   = '0;
            ld_right  = XW'(w_m1);
            ld_top    = '0;
            ld_bottom = YW'(h_m1);
            ld_color  = bg_ext[COLOR_BITS-1:0];
        end
        else
        begin
            ld_left   = (left_s < 0) ? '0 : left_s[XW-1:0];
            ld_right  = (right_s >= w_s) ? XW'(w_m1) : right_s[XW-1:0];
            ld_top    = (top_s < 0) ? '0 : top_s[YW-1:0];
            ld_bottom = (bottom_s >= h_s) ? YW'(h_m1) : bottom_s[YW-1:0];
            ld_color  = fill_ext[COLOR_BITS-1:0];
        end
    end

    assign ld_base = 32'(ld_top) * 32'(MAX_WIDTH);

    logic [XW-1:0]         lft_reg;
    logic [XW-1:0]         rgt_reg;
    logic [YW-1:0]         bot_reg;
    logic [XW-1:0]         x_reg;
    logic [YW-1:0]         y_reg;
    logic [AW-1:0]         base_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  row_end;

    assign row_end         = (x_reg == rgt_reg);
    assign stat.last_pixel = row_end && (y_reg == bot_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.init_load || ctl.decode)
        begin
            lft_reg   <= ld_left;
            rgt_reg   <= ld_right;
            bot_reg   <= ld_bottom;
            x_reg     <= ld_left;
            y_reg     <= ld_top;
            base_reg  <= ld_base[AW-1:0];
            color_reg <= ld_color;
        end
        else if (ctl.step)
        begin
            if (row_end)
            begin
                x_reg    <= lft_reg;
                y_reg    <= y_reg + YW'(1);
                base_reg <= base_reg + AW'(MAX_WIDTH);
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    // Frame store.
    logic [31:0]           rd_lin;
    logic [AW-1:0]         waddr;
    logic [COLOR_BITS-1:0] rdata;

    assign rd_lin = 32'(cap_row_reg) * 32'(MAX_WIDTH) + 32'(cap_col_reg);
    assign waddr  = base_reg + AW'(x_reg);

    crf_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.step),
        .waddr (waddr),
        .wdata (color_reg),
        .re    (ctl.rd_en),
        .raddr (rd_lin[AW-1:0]),
        .rdata (rdata)
    );

    // Result and output register.
    logic                          res_status_reg;
    logic                          res_read_reg;
    logic [COLOR_W+COLOR_BITS-1:0] rd_ext;
    logic [COLOR_W-1:0]            pixel;
    logic                          out_valid_reg;
    logic                          out_status_reg;
    logic [COLOR_W-1:0]            out_pixel_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.decode)
        begin
            res_status_reg <= reject;
            res_read_reg   <= stat.is_read && !reject;
        end
    end

    assign rd_ext = {{COLOR_W{1'b0}}, rdata};
    assign pixel  = res_read_reg ? rd_ext[COLOR_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pixel_reg  <= pixel;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{OUT_PAD_W{1'b0}}, out_pixel_reg, out_status_reg};

endmodule

`default_nettype wire

[rtl/core/clipped_rectangle_fill_top.sv]
// A read goes through the decode, read and done states before its result is loaded into the
// output register; a rejected, empty or unknown command goes from decode straight to done, and
// a clear or fill paints its pixels in turn in the paint state between the two. The done state
// waits for a free output register. One command at a time: the next beat is taken only in the
// idle state. Reset is asynchronous and active low; then a start state and a sweep of all
// MAX_WIDTH*MAX_HEIGHT pixels (4096 by default) clear the frame store before s_tready rises.
`default_nettype none

`include "clipped_rectangle_fill_top_macros.svh"

module clipped_rectangle_fill_top
    import crf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned COLOR_BITS = DEF_COLOR_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // rect_left, rect_top, rect_right, rect_bottom, fill_color, read_col, read_row
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [CMD_W-1:0]       s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status, pixel_color, zero padding
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    crf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    crf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctl       (ctl),
        .stat      (stat)
    );

    `CRF_ASSERT_SAME(a_no_input_while_painting, ctl.step, !s_tready, "input ready while painting")
    `CRF_ASSERT_SAME(a_out_load_when_free, ctl.out_load, stat.out_free, "result overwrites output")
    `CRF_ASSERT_NEXT(a_decode_after_accept, s_tvalid && s_tready, ctl.decode, "no decode after beat")
    `CRF_ASSERT_NEXT(a_busy_after_read, ctl.rd_en, !s_tready, "input ready before read result")

endmodule

`default_nettype wire
